>>> sv/pcsp_pkg.sv
// shared types and constants of the phased checkerboard stripe pattern unit
package pcsp_pkg;

	localparam int COL_W   = 12;
	localparam int ROW_W   = 12;
	localparam int FRAME_W = 32;
	localparam int COLOR_W = 24;
	localparam int CFG_W   = 13;

	// frame_number * 10 needs four more bits
	localparam int X_W = FRAME_W + 4;

	// remainder pipeline: bits of the dividend retired per stage, stage count
	localparam int DIV_BPS  = 6;
	localparam int DIV_NSTG = X_W / DIV_BPS;

	// divide by ten as multiply by reciprocal, exact below 43690
	localparam int DIV10_M  = 52429;
	localparam int DIV10_SH = 19;

	localparam logic [CFG_W-1:0]   FH_RESET   = CFG_W'(1080);
	localparam logic [COLOR_W-1:0] BAND_COLOR = 24'h00FFFF;

	// beat payload carried down the remainder pipeline
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COLOR_W-1:0] color;
		logic [X_W-1:0]     x;
	} pipe_t;

endpackage

>>> sv/pcsp_cfg.sv
// frame height register and the band geometry derived from it
module pcsp_cfg import pcsp_pkg::*; #(
	parameter int MAX_LINES = 4096,
	localparam int HW = $clog2(MAX_LINES + 1),
	localparam int RW = HW + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [CFG_W-1:0] wdata,
	output logic             busy,
	output logic [HW-1:0]    h,
	output logic [HW-1:0]    band,
	output logic [HW-1:0]    hb,
	output logic [RW-1:0]    span
);

	localparam int CMPW = ((HW > CFG_W) ? HW : CFG_W) + 1;
	localparam int PW   = HW + 20;

	typedef enum logic [2:0] {
		CFG_IDLE = 3'b001,
		CFG_LOAD = 3'b010,
		CFG_SPAN = 3'b100
	} cfg_state_t;

	cfg_state_t       state_q;
	logic [CFG_W-1:0] fh_q;
	logic [HW-1:0]    h_q, band_q, hb_q;
	logic [RW-1:0]    span_q;

	logic [HW-1:0] h_nx, band_nx;
	logic [PW-1:0] band_prod;

	// saturate at the line limit, then divide by ten
	always_comb begin
		if (CMPW'(fh_q) > CMPW'(MAX_LINES))
			h_nx = HW'(MAX_LINES);
		else
			h_nx = HW'(fh_q);
		band_prod = PW'(h_nx) * PW'(DIV10_M);
		band_nx   = band_prod[DIV10_SH +: HW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CFG_LOAD;
			fh_q    <= FH_RESET;
		end else if (we) begin
			state_q <= CFG_LOAD;
			fh_q    <= wdata;
		end else begin
			unique case (state_q)
				CFG_LOAD: state_q <= CFG_SPAN;
				CFG_SPAN: state_q <= CFG_IDLE;
				CFG_IDLE: state_q <= CFG_IDLE;
				default:  state_q <= CFG_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CFG_LOAD) begin
			h_q    <= h_nx;
			band_q <= band_nx;
		end
		if (state_q == CFG_SPAN) begin
			hb_q <= h_q - band_q;
			if (h_q > band_q)
				span_q <= {h_q - band_q, 1'b0};
			else
				span_q <= RW'(2);
		end
	end

	assign busy = (state_q != CFG_IDLE);
	assign h    = h_q;
	assign band = band_q;
	assign hb   = hb_q;
	assign span = span_q;

endmodule

>>> sv/pcsp_div_stage.sv
// one stage of the restoring remainder pipeline
module pcsp_div_stage import pcsp_pkg::*; #(
	parameter int RW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  pipe_t         in_pl,
	input  logic [RW-1:0] in_rem,
	input  logic [RW-1:0] span,
	output logic          out_vld,
	output pipe_t         out_pl,
	output logic [RW-1:0] out_rem
);

	logic          vld_q;
	pipe_t         pl_q;
	logic [RW-1:0] rem_q;

	logic [RW:0]   trial;
	logic [RW-1:0] rem_nx;

	// shift in dividend bits msb first, subtract span when it fits
	always_comb begin
		rem_nx = in_rem;
		trial  = '0;
		for (int j = 0; j < DIV_BPS; j++) begin
			trial = {rem_nx, in_pl.x[X_W-1-j]};
			if (trial >= {1'b0, span})
				trial = trial - {1'b0, span};
			rem_nx = trial[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else
			vld_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		pl_q.row   <= in_pl.row;
		pl_q.color <= in_pl.color;
		pl_q.x     <= in_pl.x << DIV_BPS;
		rem_q      <= rem_nx;
	end

	assign out_vld = vld_q;
	assign out_pl  = pl_q;
	assign out_rem = rem_q;

endmodule

>>> sv/phased_checkerboard_stripe_pattern_unit.sv
// top level of the phased checkerboard stripe pattern unit
//
// takes one pixel beat per clock (start while busy is low) and returns its rgb888
// color on pixel_color with done high for one cycle, once the beat has passed
// two input stages, the six-stage remainder pipeline that works out
// (frame_number * 10) mod span, and two band stages. results cannot be held off,
// every accepted beat yields exactly one result. busy is high after reset and after
// every write of frame_height while the band height and sweep span are derived.
module phased_checkerboard_stripe_pattern_unit import pcsp_pkg::*; #(
	parameter int MAX_LINES = 4096,
	parameter int CELL_SIZE = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [COL_W-1:0]   pixel_column,
	input  logic [ROW_W-1:0]   pixel_row,
	input  logic [FRAME_W-1:0] frame_number,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output logic               done,
	output logic [COLOR_W-1:0] pixel_color
);

	localparam int HW = $clog2(MAX_LINES + 1);
	localparam int RW = HW + 1;
	localparam int BW = ((RW > ROW_W) ? RW : ROW_W) + 1;
	// cell index as multiply by reciprocal, exact for 12-bit coordinates
	localparam int CELL_K = 20;
	localparam int CELL_M = ((1 << CELL_K) + CELL_SIZE - 1) / CELL_SIZE;
	localparam int MW     = CELL_K + 1;
	localparam int PW     = COL_W + MW;
	localparam int LAT    = DIV_NSTG + 4;

	// derived band geometry
	logic [HW-1:0] h_w, band_w, hb_w;
	logic [RW-1:0] span_w;

	pcsp_cfg #(.MAX_LINES(MAX_LINES)) u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.wdata (cfg_wdata),
		.busy  (busy),
		.h     (h_w),
		.band  (band_w),
		.hb    (hb_w),
		.span  (span_w)
	);

	logic accept;
	assign accept = start && !busy;

	// stage 1: cell indexes (low bits only matter), frame terms
	logic [PW-1:0]   col_prod, row_prod;
	logic            vld_s1;
	logic [2:0]      qc_s1, qr_s1;
	logic [7:0]      t_s1;
	logic [ROW_W-1:0] row_s1;
	logic [X_W-1:0]  x_s1;

	always_comb begin
		col_prod = PW'(pixel_column) * PW'(CELL_M);
		row_prod = PW'(pixel_row) * PW'(CELL_M);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		qc_s1  <= col_prod[CELL_K +: 3];
		qr_s1  <= row_prod[CELL_K +: 3];
		t_s1   <= frame_number[8:1];
		row_s1 <= pixel_row;
		// frame * 10 as frame * 8 + frame * 2
		x_s1   <= X_W'({frame_number, 3'b000}) + X_W'({frame_number, 1'b0});
	end

	// stage 2: checkerboard color
	logic [2:0] cell_sum;
	logic [7:0] phase, nphase;
	logic [COLOR_W-1:0] board_color;

	always_comb begin
		cell_sum = qc_s1 + qr_s1;
		// phase wraps at 256, so only the low three bits of the cell sum count
		phase    = {cell_sum, 5'b00000} + t_s1 + {t_s1[6:0], 1'b0};
		nphase   = 8'hFF - phase;
		if (cell_sum[0])
			board_color = {phase, nphase, 1'b0, phase[7:1]};
		else
			board_color = {nphase, 1'b0, phase[7:1], phase};
	end

	logic  vld_s2;
	pipe_t pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		pl_s2.row   <= row_s1;
		pl_s2.color <= board_color;
		pl_s2.x     <= x_s1;
	end

	// remainder pipeline: band start offset p = (frame * 10) mod span
	logic          div_vld [DIV_NSTG+1];
	pipe_t         div_pl  [DIV_NSTG+1];
	logic [RW-1:0] div_rem [DIV_NSTG+1];

	assign div_vld[0] = vld_s2;
	assign div_pl[0]  = pl_s2;
	assign div_rem[0] = '0;

	for (genvar k = 0; k < DIV_NSTG; k++) begin : g_div
		pcsp_div_stage #(.RW(RW)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (div_vld[k]),
			.in_pl  (div_pl[k]),
			.in_rem (div_rem[k]),
			.span   (span_w),
			.out_vld(div_vld[k+1]),
			.out_pl (div_pl[k+1]),
			.out_rem(div_rem[k+1])
		);
	end

	// stage 9: fold the offset into a triangle wave for the band top
	logic [RW-1:0]      p_w, y0_nx;
	logic               vld_s9;
	logic [RW-1:0]      y0_s9;
	logic [ROW_W-1:0]   row_s9;
	logic [COLOR_W-1:0] color_s9;

	always_comb begin
		p_w = div_rem[DIV_NSTG];
		if (p_w < RW'(hb_w))
			y0_nx = p_w;
		else
			y0_nx = span_w - p_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else
			vld_s9 <= div_vld[DIV_NSTG];
	end

	always_ff @(posedge clk) begin
		y0_s9    <= y0_nx;
		row_s9   <= div_pl[DIV_NSTG].row;
		color_s9 <= div_pl[DIV_NSTG].color;
	end

	// stage 10: band hit test, output register
	logic [BW-1:0] row_x, y0_x, end_x;
	logic          band_hit;
	logic          vld_s10;
	logic [COLOR_W-1:0] color_s10;

	always_comb begin
		row_x = BW'(row_s9);
		y0_x  = BW'(y0_s9);
		end_x = y0_x + BW'(band_w);
		// rows past the last visible line never see the band
		band_hit = (row_x >= y0_x) && (row_x < end_x) && (row_x < BW'(h_w));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s10 <= 1'b0;
		else
			vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		color_s10 <= band_hit ? BAND_COLOR : color_s9;
	end

	assign done        = vld_s10;
	assign pixel_color = color_s10;

	// every accepted beat comes out after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted beat did not produce a result");

	// no result without a beat accepted the fixed latency earlier
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching accepted beat");

	// a height write blocks beats until the geometry is rebuilt
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("busy low right after a height write");

	// sweep span is twice the travel, or two for an empty frame
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ((span_w == {hb_w, 1'b0}) || ((hb_w == '0) && (span_w == RW'(2)))))
		else $error("sweep span inconsistent with band travel");

endmodule
